// ===== sv/mxt_pkg.sv =====
// ----------------------------------------------------------------------------
// mxt_pkg: shared definitions for the max subarray xor tracker
// Field widths, parameter defaults and the status bundle from the sequencer.
// ----------------------------------------------------------------------------
package mxt_pkg;

   // fixed widths of the stream fields
   localparam int VALUE_WIDTH = 8;
   localparam int BEST_WIDTH  = 8;

   // datapath width default and allowed range
   localparam int DEF_VALUE_BITS = 8;
   localparam int MIN_VALUE_BITS = 1;
   localparam int MAX_VALUE_BITS = 12;

   // sequencer status seen by the top level
   typedef struct packed {
      logic busy;   // sequencer not idle, no item taken
      logic fin;    // result waiting to move to the output register
   } seq_status_type;

endpackage

// ===== sv/max_subarray_xor_tracker.sv =====
// ----------------------------------------------------------------------------
// max_subarray_xor_tracker: largest xor of any contiguous run in a stream
//
//   channel | dir | tdata                 | tuser
//   req_    | in  | [7:0] value           | [0] start_sequence
//   rsp_    | out | [7:0] best_xor        | -
//
// From accept to the output register an item first marks the prefix, then
// does one bitmap read per candidate, the read data being registered, then
// hands over the result once the output register is free.
// An item with start_sequence first sweeps the bitmap.
// After reset the same sweep runs with req_tready low.
// A result waiting in the output register does not block the next item.
// ----------------------------------------------------------------------------
module max_subarray_xor_tracker #(
   parameter int VALUE_BITS = mxt_pkg::DEF_VALUE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mxt_pkg::VALUE_WIDTH-1:0] req_tdata,  // [7:0] value
   input  logic                           req_tuser,  // [0] start_sequence
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mxt_pkg::BEST_WIDTH-1:0]  rsp_tdata   // [7:0] best_xor
);

   localparam int InW   = (VALUE_BITS > mxt_pkg::VALUE_WIDTH) ? VALUE_BITS
                                                              : mxt_pkg::VALUE_WIDTH;
   localparam int BestW = (VALUE_BITS > mxt_pkg::BEST_WIDTH) ? VALUE_BITS
                                                             : mxt_pkg::BEST_WIDTH;

   mxt_pkg::seq_status_type status;

   logic                  item_go;
   logic [InW-1:0]        value_ext;
   logic [VALUE_BITS-1:0] item_value;
   logic                  rsp_free;
   logic                  rsp_load;
   logic                  mem_we;
   logic [VALUE_BITS-1:0] mem_waddr;
   logic                  mem_wdata;
   logic [VALUE_BITS-1:0] mem_raddr;
   logic                  mem_rdata;
   logic [VALUE_BITS-1:0] best;
   logic [BestW-1:0]      best_ext;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [mxt_pkg::BEST_WIDTH-1:0]  rsp_tdata_ff, rsp_tdata_in;

   assign req_tready = !status.busy;
   assign item_go    = req_tvalid && req_tready;
   assign value_ext  = InW'(req_tdata);
   assign item_value = value_ext[VALUE_BITS-1:0];

   mxt_seq #(
      .VALUE_BITS(VALUE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_go    (item_go),
      .item_value (item_value),
      .item_start (req_tuser),
      .rsp_free   (rsp_free),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .best       (best),
      .status     (status)
   );

   mxt_bitmap #(
      .VALUE_BITS(VALUE_BITS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load     = status.fin && rsp_free;
   assign best_ext     = BestW'(best);
   assign rsp_tdata_in = rsp_load ? best_ext[mxt_pkg::BEST_WIDTH-1:0] : rsp_tdata_ff;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // bitmap sweep runs right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("item taken before the bitmap sweep");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer idle right after an accept");

   // a finished result is always followed by a loaded output register
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid && !status.fin))
      else $error("finished result did not reach the output register");

endmodule

// ===== sv/mxt_bitmap.sv =====
// ----------------------------------------------------------------------------
// mxt_bitmap: presence bitmap of prefix values
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mxt_bitmap #(
   parameter int VALUE_BITS = mxt_pkg::DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [VALUE_BITS-1:0] wr_addr,
   input  logic                  wr_data,
   input  logic [VALUE_BITS-1:0] rd_addr,
   output logic                  rd_data
);

   localparam int Depth = 1 << VALUE_BITS;

   logic mem [Depth];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mxt_seq.sv =====
// ----------------------------------------------------------------------------
// mxt_seq: sequencer and scan datapath
// Clears the bitmap after reset or on a start item, marks the new prefix,
// then walks candidates down through one xor and compare until a partner is found.
// ----------------------------------------------------------------------------
module mxt_seq #(
   parameter int VALUE_BITS = mxt_pkg::DEF_VALUE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_go,
   input  logic [VALUE_BITS-1:0]  item_value,
   input  logic                   item_start,
   input  logic                   rsp_free,
   output logic                   mem_we,
   output logic [VALUE_BITS-1:0]  mem_waddr,
   output logic                   mem_wdata,
   output logic [VALUE_BITS-1:0]  mem_raddr,
   input  logic                   mem_rdata,
   output logic [VALUE_BITS-1:0]  best,
   output mxt_pkg::seq_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_MARK  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam logic [VALUE_BITS-1:0] TopIdx = '1;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] prefix_ff, prefix_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [VALUE_BITS-1:0] cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] tag_ff, tag_in;
   logic                  rvld_ff, rvld_in;
   logic                  pend_ff, pend_in;
   logic [VALUE_BITS-1:0] next_prefix;

   assign next_prefix = prefix_ff ^ val_ff;

   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      prefix_in = prefix_ff;
      best_in   = best_ff;
      cnt_in    = cnt_ff;
      tag_in    = cnt_ff;
      rvld_in   = 1'b0;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = 1'b0;
      mem_raddr = prefix_ff ^ cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_go) begin
               val_in = item_value;
               if (item_start) begin
                  prefix_in = '0;
                  best_in   = '0;
                  cnt_in    = '0;
                  pend_in   = 1'b1;
                  state_in  = ST_CLEAR;
               end else begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_CLEAR: begin
            // sweep: only entry zero stays present
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = (cnt_ff == '0);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == TopIdx) begin
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_MARK : ST_IDLE;
            end
         end
         ST_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = next_prefix;
            mem_wdata = 1'b1;
            prefix_in = next_prefix;
            cnt_in    = TopIdx;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // read issued for cnt_ff, data of tag_ff checked in the next cycle
            rvld_in = 1'b1;
            tag_in  = cnt_ff;
            cnt_in  = cnt_ff - 1'b1;
            if (rvld_ff && mem_rdata) begin
               if (tag_ff > best_ff) begin
                  best_in = tag_ff;
               end
               rvld_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         prefix_ff <= '0;
         best_ff   <= '0;
         cnt_ff    <= '0;
         rvld_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         best_ff   <= best_in;
         cnt_ff    <= cnt_in;
         rvld_ff   <= rvld_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      tag_ff <= tag_in;
   end

   assign best        = best_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.fin  = (state_ff == ST_DONE);

endmodule

// ===== verif/tb_max_subarray_xor_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_max_subarray_xor_tracker: self-checking bench for the xor run tracker
// Drives a short table of fixed items, then random sequences with random
// idling on both channels and one long output hold-off. A software copy of
// the prefix set and best value predicts each best_xor not known by hand; all
// are compared in order against what the block returns.
// ----------------------------------------------------------------------------
module tb_max_subarray_xor_tracker;

   localparam int VALUE_SPAN      = 1 << mxt_pkg::VALUE_WIDTH;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 2 * VALUE_SPAN + 40;

   typedef logic [mxt_pkg::VALUE_WIDTH-1:0] value_type;
   typedef logic [mxt_pkg::BEST_WIDTH-1:0]  best_type;

   typedef enum int {FILL_FULL, FILL_MASKED, FILL_EXTREME, FILL_HIGH} fill_mode_type;

   typedef struct packed {
      value_type value;
      logic      start;
      logic      typed;   // best below is known by hand
      best_type  best;
   } dir_row_type;

   localparam int DIR_ROWS = 23;
   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 8'h00},   // first item without a start mark
      '{8'hFF, 1'b0, 1'b1, 8'hFF},
      '{8'h00, 1'b1, 1'b1, 8'h00},   // start drops the best back to zero
      '{8'h01, 1'b0, 1'b1, 8'h01},
      '{8'h01, 1'b0, 1'b0, 8'h00},   // prefix returns to zero
      '{8'h80, 1'b1, 1'b1, 8'h80},
      '{8'h7F, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b1, 1'b1, 8'hFF},
      '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'h01, 1'b1, 1'b1, 8'h01},
      '{8'h02, 1'b0, 1'b0, 8'h00},
      '{8'h04, 1'b0, 1'b0, 8'h00},
      '{8'h08, 1'b0, 1'b0, 8'h00},
      '{8'h10, 1'b1, 1'b1, 8'h10},
      '{8'h20, 1'b0, 1'b0, 8'h00},
      '{8'h40, 1'b0, 1'b0, 8'h00},
      '{8'h80, 1'b0, 1'b0, 8'h00},
      '{8'hAA, 1'b1, 1'b1, 8'hAA},
      '{8'h55, 1'b0, 1'b0, 8'h00},
      '{8'h0F, 1'b1, 1'b1, 8'h0F},
      '{8'hF0, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b1, 8'h00}    // zero item that carries a start mark
   };

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   value_type req_tdata  = '0;
   logic      req_tuser  = 1'b0;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   best_type  rsp_tdata;

   // software copy of the tracker state
   value_type prefix_acc;
   bit        seen_prefix [VALUE_SPAN];
   best_type  best_acc;

   best_type  pending_best [$];
   int        mismatch_count   = 0;
   int        send_idle_pct    = 0;
   int        recv_stall_pct   = 0;
   bit        hold_off_request = 1'b0;

   max_subarray_xor_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] value
      .req_tuser  (req_tuser),    // [0] start_sequence
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [7:0] best_xor
   );

   always #4 clock = ~clock;

   initial begin
      #50_000_000;
      $display("FAIL max_subarray_xor_tracker");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_xor_state();
      prefix_acc = '0;
      foreach (seen_prefix[i]) seen_prefix[i] = 1'b0;
      seen_prefix[0] = 1'b1;
      best_acc = '0;
   endfunction

   // fold one value into the prefix and return the best run xor so far
   function automatic best_type fold_value(input value_type value, input logic start);
      int        cand;
      bit        hit;
      value_type found;
      if (start) clear_xor_state();
      prefix_acc = prefix_acc ^ value;
      seen_prefix[prefix_acc] = 1'b1;
      found = '0;
      hit   = 1'b0;
      for (cand = VALUE_SPAN - 1; cand >= 0 && !hit; cand--) begin
         if (seen_prefix[prefix_acc ^ value_type'(cand)]) begin
            found = value_type'(cand);
            hit   = 1'b1;
         end
      end
      if (found > best_acc) best_acc = found;
      return best_acc;
   endfunction

   function automatic value_type pick_value(input fill_mode_type mode,
                                            input value_type mask);
      case (mode)
         FILL_MASKED: return value_type'($urandom) & mask;
         FILL_EXTREME: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return '1;
               default: return value_type'(1)
                               << $urandom_range(mxt_pkg::VALUE_WIDTH - 1);
            endcase
         end
         FILL_HIGH: return value_type'($urandom)
                           | (value_type'(1) << (mxt_pkg::VALUE_WIDTH - 1));
         default:   return value_type'($urandom);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the accept
   // with req_tvalid still high so back-to-back items need no extra toggle
   task automatic send_item(input value_type value, input logic start,
                            input logic typed, input best_type typed_best);
      best_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = fold_value(value, start);
      pending_best.push_back(typed ? typed_best : predicted);
      @(negedge clock);
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      int            sent;
      int            seq_len;
      int            k;
      bit            fresh;
      logic          start;
      fill_mode_type mode;
      value_type     mask;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         seq_len = $urandom_range(1, 40);
         mode    = fill_mode_type'($urandom_range(3));
         mask    = value_type'((1 << $urandom_range(1, 4)) - 1);
         // mostly proper sequences, sometimes a run that just continues
         fresh   = ($urandom_range(9) != 0);
         for (k = 0; k < seq_len && sent < count; k++) begin
            start = (k == 0 && fresh) || ($urandom_range(49) == 0);
            send_item(pick_value(mode, mask), start, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // output side: random stalls plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_best.size() == 0) begin
            report_mismatch($sformatf("unexpected best_xor %02h", rsp_tdata));
         end else begin
            if (rsp_tdata !== pending_best[0]) begin
               report_mismatch($sformatf("best_xor %02h, want %02h",
                                         rsp_tdata, pending_best[0]));
            end
            void'(pending_best.pop_front());
         end
      end
   end

   initial begin
      clear_xor_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].start,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].best);
      end

      run_random(350, 0, 0);
      // long output hold-off while items keep coming, fills the block
      hold_off_request = 1'b1;
      run_random(40, 0, 0);
      run_random(300, 74, 0);
      run_random(300, 0, 74);
      run_random(260, 13, 13);

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (pending_best.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS max_subarray_xor_tracker");
      end else begin
         $display("FAIL max_subarray_xor_tracker");
      end
      $finish;
   end

endmodule
